>>> rtl/u16u8_pkg.sv
// ============================================================================
// u16u8_pkg
// Shared types, constants and byte-forming functions for the UTF-16 to UTF-8
// encoder.
// ============================================================================
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;  // 0xD800..0xDBFF
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;  // 0xDC00..0xDFFF
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // One decoded job: up to two code points and the end-of-string flag
    typedef struct packed {
        logic [20:0] cp_a;
        logic [2:0]  len_a;
        logic [15:0] cp_b;
        logic [1:0]  len_b;
        logic        last;
    } u16u8_job_t;

    typedef struct packed {
        logic       valid;
        u16u8_job_t job;
    } u16u8_push_t;

    // Number of UTF-8 bytes for a code point
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp < 21'h80) begin
            len = 3'd1;
        end else if (cp < 21'h800) begin
            len = 3'd2;
        end else if (cp < 21'h10000) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Byte idx (0 = lead) of the len-byte sequence of cp
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [2:0]  len,
                                             input logic [2:0]  idx);
        logic [7:0] b;
        logic [2:0] rem;
        rem = len - idx - 3'd1;
        if (idx == 3'd0) begin
            unique case (len)
                3'd1:    b = {1'b0, cp[6:0]};
                3'd2:    b = {3'b110, cp[10:6]};
                3'd3:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            unique case (rem)
                3'd0:    b = {2'b10, cp[5:0]};
                3'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

>>> rtl/u16u8_front.sv
// ============================================================================
// u16u8_front
// Accepts code units, pairs surrogates and pushes byte jobs to the queue.
// ============================================================================
module u16u8_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output u16u8_pkg::u16u8_push_t q_push
);
    import u16u8_pkg::*;

    logic       pair_reg;
    logic       held_reg, held_next;
    logic [9:0] held_bits_reg, held_bits_next;

    logic       accept;
    logic       is_high, is_low, hold_new;
    logic [2:0] unit_len;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign is_high   = (s_tdata[15:10] == SURR_HIGH_TAG);
    assign is_low    = (s_tdata[15:10] == SURR_LOW_TAG);
    assign hold_new  = pair_reg && is_high && !s_tlast;
    assign unit_len  = utf8_len({5'b0, s_tdata});

    always_comb begin
        held_next      = held_reg;
        held_bits_next = held_bits_reg;
        q_push.valid   = 1'b0;
        q_push.job     = '0;
        q_push.job.last = s_tlast;
        if (accept) begin
            if (held_reg && is_low) begin
                // complete the pair
                q_push.valid     = 1'b1;
                q_push.job.cp_a  = {1'b0, held_bits_reg, s_tdata[9:0]} + SUPP_BASE;
                q_push.job.len_a = 3'd4;
                held_next        = 1'b0;
            end else begin
                if (held_reg) begin
                    // flush the stale high surrogate first
                    q_push.valid     = 1'b1;
                    q_push.job.cp_a  = {5'b0, SURR_HIGH_TAG, held_bits_reg};
                    q_push.job.len_a = 3'd3;
                    held_next        = 1'b0;
                end
                if (hold_new) begin
                    held_next      = 1'b1;
                    held_bits_next = s_tdata[9:0];
                end else if (held_reg) begin
                    q_push.job.cp_b  = s_tdata;
                    q_push.job.len_b = unit_len[1:0];
                end else begin
                    q_push.valid     = 1'b1;
                    q_push.job.cp_a  = {5'b0, s_tdata};
                    q_push.job.len_a = unit_len;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg      <= 1'b0;
            held_reg      <= 1'b0;
            held_bits_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pair_reg <= cfg_data;
            end
            held_reg      <= held_next;
            held_bits_reg <= held_bits_next;
        end
    end

endmodule

>>> rtl/u16u8_queue.sv
// ============================================================================
// u16u8_queue
// Small job queue between the front and back ends.
// ============================================================================
module u16u8_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  u16u8_pkg::u16u8_push_t q_push,
    output logic                   q_full,
    input  logic                   q_pop,
    output logic                   q_valid,
    output u16u8_pkg::u16u8_job_t  q_head
);
    import u16u8_pkg::*;

    u16u8_job_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign q_full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (QUEUE_PTR_W)'(q_push.valid);
        rd_ptr_next = rd_ptr_reg + (QUEUE_PTR_W)'(q_pop);
        count_next  = count_reg + (QUEUE_PTR_W+1)'(q_push.valid)
                                - (QUEUE_PTR_W+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            entry_reg[wr_ptr_reg] <= q_push.job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

>>> rtl/u16u8_back.sv
// ============================================================================
// u16u8_back
// Walks the head job byte by byte into the output register.
// ============================================================================
module u16u8_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  u16u8_pkg::u16u8_job_t q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic [0:0]            m_tuser
);
    import u16u8_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic       load, emit, last_byte;
    logic [2:0] total;
    logic [2:0] idx_b;
    logic [7:0] byte_val;

    assign load      = !m_tvalid_reg || m_tready;
    assign emit      = q_valid && load;
    assign total     = q_head.len_a + {1'b0, q_head.len_b};
    assign last_byte = (idx_reg + 3'd1 == total);
    assign idx_b     = idx_reg - q_head.len_a;
    assign q_pop     = emit && last_byte;

    always_comb begin
        if (idx_reg < q_head.len_a) begin
            byte_val = utf8_byte(q_head.cp_a, q_head.len_a, idx_reg);
        end else begin
            byte_val = utf8_byte({5'b0, q_head.cp_b}, {1'b0, q_head.len_b}, idx_b);
        end
        m_tvalid_next = load ? q_valid : m_tvalid_reg;
        idx_next      = idx_reg;
        if (emit) begin
            idx_next = last_byte ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= byte_val;
            m_tlast_reg <= last_byte;
            m_tuser_reg <= last_byte && q_head.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_end_on_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[0] || m_tlast))
        else $error("string end without run end");

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (idx_reg < total))
        else $error("byte index past job length");

    a_stall_holds_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(idx_reg))
        else $error("byte index moved during stall");

endmodule

>>> rtl/utf16_to_utf8_encoder.sv
// ============================================================================
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, optional surrogate pairing.
// ============================================================================
//  channel  dir  payload                                 handshake
//  s_       in   tdata[15:0]=code_unit, tlast=last_unit  s_tvalid/s_tready
//  m_       out  tdata[7:0]=out_byte, tlast=run_last,    m_tvalid/m_tready
//                tuser[0]=string_end
//  cfg_     in   cfg_data=pair_surrogates                cfg_valid/cfg_ready
//
//  Output runs at one byte per cycle unless m_tready stalls it; a unit yields 1 to 4
//  bytes (up to 6 when a held surrogate is flushed), formed by the byte walker.
//  A held high surrogate produces no bytes until the next unit arrives.
//  A four-entry job queue lets input run ahead while the output stalls.
//  Reset (aresetn low, synchronous) clears the queue, the hold and pairing.
// ============================================================================
module utf16_to_utf8_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] string_end
);
    import u16u8_pkg::*;

    u16u8_push_t q_push;
    u16u8_job_t  q_head;
    logic        q_full, q_valid, q_pop;

    u16u8_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    u16u8_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    u16u8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: UTF-16 to UTF-8 encoder testbench
// Streams code units into the encoder and checks every output byte, with its
// run and string-end flags, against a cycle-free prediction of the encoding.
// Covers both pairing modes, surrogate corner cases, random strings and long
// output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 150;
    localparam int MAX_REPORTS   = 10;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    typedef enum logic {RX_ALWAYS, RX_RANDOM} rx_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } utf8_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [15:0] code_unit
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;
    logic [0:0]  m_tuser;          // [0] string_end

    // encoder state as predicted from the accepted transfers
    logic       pair_mode  = 1'b0;
    logic       held_valid = 1'b0;
    logic [9:0] held_bits  = '0;

    utf8_beat_t  expected_beats[$];
    logic [7:0]  unit_bytes[$];
    int          error_count = 0;
    int          cycle_count = 0;

    // sender pacing
    int gap_max    = 0;
    int burst_left = 0;

    // receiver pacing
    rx_mode_t rx_mode     = RX_RANDOM;
    int       hold_reqs   = 0;
    int       hold_served = 0;
    int       hold_left   = 0;
    int       rx_left     = 0;
    logic     rx_phase    = 1'b1;

    utf16_to_utf8_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void append_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            unit_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            unit_bytes.push_back(8'hC0 | 8'(cp >> 6));
            unit_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
        end else if (cp < 21'h10000) begin
            unit_bytes.push_back(8'hE0 | 8'(cp >> 12));
            unit_bytes.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
            unit_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
        end else begin
            unit_bytes.push_back(8'hF0 | 8'((cp >> 18) & 21'h07));
            unit_bytes.push_back(8'h80 | 8'((cp >> 12) & 21'h3F));
            unit_bytes.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
            unit_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
        end
    endfunction

    function automatic void predict_unit(input logic [15:0] unit, input logic last);
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        utf8_beat_t  beat;
        is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
        is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
        unit_bytes.delete();
        if (held_valid && is_low) begin
            // a held high surrogate always combines with a low one
            cp = 21'h10000 + {held_bits, 10'd0} + 21'(unit - LOW_FIRST);
            held_valid = 1'b0;
            held_bits  = '0;
            append_code_point(cp);
        end else begin
            if (held_valid) begin
                append_code_point(21'(HIGH_FIRST) | 21'(held_bits));
                held_valid = 1'b0;
                held_bits  = '0;
            end
            if (pair_mode && is_high && !last) begin
                held_valid = 1'b1;
                held_bits  = 10'(unit - HIGH_FIRST);
            end else begin
                append_code_point(21'(unit));
            end
        end
        foreach (unit_bytes[i]) begin
            beat.data     = unit_bytes[i];
            beat.run_last = (i == unit_bytes.size() - 1);
            beat.str_end  = beat.run_last && last;
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Transfer monitor and byte checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : byte_checker
        utf8_beat_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                pair_mode = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                predict_unit(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    note_error($sformatf("unexpected byte %02h last=%0b end=%0b",
                                         m_tdata, m_tlast, m_tuser[0]));
                end else begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.run_last ||
                        m_tuser[0] !== want.str_end) begin
                        note_error($sformatf(
                            "byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                            want.data, want.run_last, want.str_end,
                            m_tdata, m_tlast, m_tuser[0]));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready/stall runs, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_served != hold_reqs) begin
            hold_served <= hold_reqs;
            hold_left   <= LONG_HOLD;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            m_tready <= 1'b1;
        end else if (rx_left == 0) begin
            rx_phase <= ~rx_phase;
            rx_left  <= rx_phase ? $urandom_range(1, 4) : $urandom_range(1, 8);
            m_tready <= ~rx_phase;
        end else begin
            rx_left  <= rx_left - 1;
            m_tready <= rx_phase;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic apply_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic send_unit(input logic [15:0] unit, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                burst_left = $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold input until every predicted byte is out, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        // let the checker record the transfer of the edge just passed
        @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pairing(input logic enable);
        cfg_data  <= enable;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] random_unit(input int kind);
        if (kind < 45) begin
            return 16'($urandom_range(0, 'h7F));
        end else if (kind < 60) begin
            return 16'($urandom_range('h80, 'h7FF));
        end else if (kind < 75) begin
            if ($urandom_range(0, 1) == 0) begin
                return 16'($urandom_range('h800, 'hD7FF));
            end
            return 16'($urandom_range('hE000, 'hFFFF));
        end else if (kind < 83) begin
            return HIGH_FIRST + 16'($urandom_range(0, 'h3FF));
        end else if (kind < 90) begin
            return LOW_FIRST + 16'($urandom_range(0, 'h3FF));
        end
        return 16'($urandom);
    endfunction

    // strings of random length, mostly well-formed, each closed by its last unit
    task automatic send_random_strings(input int unit_target);
        int sent;
        int left;
        int kind;
        sent = 0;
        while (sent < unit_target) begin
            left = $urandom_range(1, 12);
            while (left > 0) begin
                kind = $urandom_range(0, 99);
                if (kind < 20 && left >= 2) begin
                    send_unit(HIGH_FIRST + 16'($urandom_range(0, 'h3FF)), 1'b0);
                    send_unit(LOW_FIRST + 16'($urandom_range(0, 'h3FF)), left == 2);
                    left -= 2;
                    sent += 2;
                end else begin
                    send_unit(random_unit(kind < 20 ? 20 : kind), left == 1);
                    left--;
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_unit_ranges();
        write_pairing(1'b0);
        gap_max = 3;
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(HIGH_FIRST, 1'b0);    // not held with pairing off
        send_unit(LOW_LAST, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        drain_results();
    endtask

    task automatic test_surrogate_pairs();
        write_pairing(1'b1);
        send_unit(HIGH_FIRST, 1'b0);
        send_unit(LOW_FIRST, 1'b0);
        send_unit(HIGH_LAST, 1'b0);
        send_unit(LOW_LAST, 1'b1);      // highest code point
        send_unit(16'hD83D, 1'b0);
        send_unit(16'h0041, 1'b0);      // flush held, then plain unit
        send_unit(16'hD800, 1'b0);
        send_unit(16'hD801, 1'b0);      // flush held, hold the new one
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hD802, 1'b0);
        send_unit(16'hDBFE, 1'b1);      // flush plus last high: six bytes
        send_unit(LOW_FIRST, 1'b0);     // lone low
        send_unit(HIGH_LAST, 1'b1);     // high at string end is never held
        drain_results();
        // hold across a register write: the pair still combines
        send_unit(16'hD801, 1'b0);
        drain_results();
        write_pairing(1'b0);
        send_unit(16'hDC05, 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic();
        write_pairing(1'b0);
        gap_max = 6;
        rx_mode <= RX_RANDOM;
        send_random_strings(70);
        drain_results();

        write_pairing(1'b1);
        send_random_strings(110);
        drain_results();

        // a stretch with no idling on either side
        write_pairing(1'b1);
        gap_max = 0;
        rx_mode <= RX_ALWAYS;
        send_random_strings(60);
        drain_results();

        write_pairing(1'b0);
        gap_max = 2;
        rx_mode <= RX_RANDOM;
        send_random_strings(40);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_pairing(1'b1);
        gap_max = 0;
        rx_mode   <= RX_ALWAYS;
        hold_reqs <= hold_reqs + 1;
        // keep offering while the output is held off, so the input stalls
        send_random_strings(40);
        drain_results();
        gap_max = 4;
        rx_mode <= RX_RANDOM;
        send_random_strings(20);
        drain_results();
    endtask

    initial begin
        apply_reset();
        test_unit_ranges();
        test_surrogate_pairs();
        test_random_traffic();
        test_backpressure();
        drain_results();
        if (error_count == 0 && expected_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> utf16_to_utf8_encoder.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder.sv
dv/tb_top.sv
